@@ sv/bbt_pkg.sv @@
// ----------------------------------------------------------------------------
// bbt_pkg: shared types and constants for the beat interval BPM tracker
// Widths, reset values, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package bbt_pkg;

    // field widths
    localparam int TS_W     = 32;
    localparam int LIM_W    = 12;
    localparam int RING_W   = 12;
    localparam int VAL_W    = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // serial subtractor: one digit per cycle
    localparam int DIGIT_W   = 4;
    localparam int SUB_STEPS = TS_W / DIGIT_W;
    localparam int SUB_CNT_W = $clog2(SUB_STEPS);

    // serial divider: one quotient bit per cycle
    localparam int DIV_W     = VAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // reset values and fixed constants
    localparam int WINDOW_LEN_DEF = 10;
    localparam logic [LIM_W-1:0]  LOW_RESET      = LIM_W'(300);
    localparam logic [LIM_W-1:0]  HIGH_RESET     = LIM_W'(2000);
    localparam logic [RING_W-1:0] START_INTERVAL = RING_W'(1000);
    localparam logic [VAL_W-1:0]  MS_PER_MINUTE  = VAL_W'(60000);

    // register indexes (address bit 2 selects the register)
    localparam logic REG_LOW  = 1'b0;
    localparam logic REG_HIGH = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_CHECK,
        ST_AVG,
        ST_RATE,
        ST_RANGE,
        ST_DONE
    } bbt_state_t;

endpackage

@@ sv/beat_interval_bpm_tracker.sv @@
// ----------------------------------------------------------------------------
// beat_interval_bpm_tracker: rolling-average heart rate from pulse edges
// Measures beat intervals, keeps a ring of recent ones and reports BPM.
// ----------------------------------------------------------------------------
// Input items (in_valid / in_stall / edge_time_ms) carry one pulse edge each;
// the output channel (out_valid / out_stall / result fields) returns exactly
// one result item per input item, in order. The APB port sets the low and
// high interval limits (addresses 0 and 4); write them only while idle.
// One item at a time: in_stall is high while an item is in work. Each item
// goes through the 4-bit serial subtractor (8 steps); a rejected interval
// then goes to the output register, an accepted one first through the
// shared 1-bit serial divider, for the average and then for the rate (16
// steps each; the rate step is skipped when the average is zero). Reset
// loads every ring entry with 1000 ms, the total with 1000 * WINDOW_LEN and
// clears rate, min, max and the previous edge time. A stalled result holds
// in the output register; the next item may be worked meanwhile, then the
// sequencer waits with it until the register frees.
// ----------------------------------------------------------------------------
module beat_interval_bpm_tracker
    import bbt_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input items
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [TS_W-1:0]   edge_time_ms,
    // result items
    output logic              out_valid,
    input  logic              out_stall,
    output logic              accepted,
    output logic [VAL_W-1:0]  interval_ms,
    output logic [VAL_W-1:0]  bpm,
    output logic [VAL_W-1:0]  bpm_min,
    output logic [VAL_W-1:0]  bpm_max,
    output logic              min_changed,
    output logic              max_changed,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [VAL_W-1:0] TOTAL_RESET = VAL_W'(WINDOW_LEN * 1000);

    // configuration registers
    logic [LIM_W-1:0] low_reg;
    logic [LIM_W-1:0] high_reg;

    // tracker state
    bbt_state_t        state_reg;
    bbt_state_t        state_next;
    logic [TS_W-1:0]   prev_reg;
    logic [RING_W-1:0] ring_reg [WINDOW_LEN];
    logic [SLOT_W-1:0] slot_reg;
    logic [VAL_W-1:0]  total_reg;
    logic [VAL_W-1:0]  total_next;
    logic [VAL_W-1:0]  bpm_reg;
    logic [VAL_W-1:0]  min_reg;
    logic [VAL_W-1:0]  max_reg;
    logic              cal_reg;
    logic              acc_reg;
    logic              minc_reg;
    logic              maxc_reg;

    // output register
    logic              out_valid_reg;
    logic              o_acc_reg;
    logic [VAL_W-1:0]  o_int_reg;
    logic [VAL_W-1:0]  o_bpm_reg;
    logic [VAL_W-1:0]  o_min_reg;
    logic [VAL_W-1:0]  o_max_reg;
    logic              o_minc_reg;
    logic              o_maxc_reg;

    // arithmetic units
    logic              sub_start;
    logic              sub_done;
    logic [TS_W-1:0]   interval;
    logic              div_start;
    logic [DIV_W-1:0]  div_dvd;
    logic [DIV_W-1:0]  div_dvs;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;

    logic              in_band;
    logic              out_free;
    logic [VAL_W-1:0]  int_sat;

    bbt_sub_serial u_sub (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (sub_start),
        .minuend    (edge_time_ms),
        .subtrahend (prev_reg),
        .done       (sub_done),
        .diff       (interval)
    );

    bbt_div_serial u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // APB register access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HIGH) ? APB_DW'(high_reg) : APB_DW'(low_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= LOW_RESET;
            high_reg <= HIGH_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_LOW)
                low_reg <= pwdata[LIM_W-1:0];
            else
                high_reg <= pwdata[LIM_W-1:0];
        end
    end

    // interval checks
    assign in_band  = (interval > TS_W'(low_reg)) && (interval < TS_W'(high_reg));
    assign int_sat  = (|interval[TS_W-1:VAL_W]) ? {VAL_W{1'b1}} : interval[VAL_W-1:0];
    assign total_next = total_reg - VAL_W'(ring_reg[slot_reg]) + interval[VAL_W-1:0];
    assign out_free = !out_valid_reg || !out_stall;

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencer next state and unit starts
    always_comb
    begin
        state_next = state_reg;
        sub_start  = 1'b0;
        div_start  = 1'b0;
        div_dvd    = total_next;
        div_dvs    = VAL_W'(WINDOW_LEN);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sub_start  = 1'b1;
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                if (sub_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (in_band)
                begin
                    div_start  = 1'b1;
                    state_next = ST_AVG;
                end
                else
                    state_next = ST_DONE;
            end
            ST_AVG:
            begin
                if (div_done)
                begin
                    if (div_quo == '0)
                        state_next = ST_RANGE;
                    else
                    begin
                        div_start  = 1'b1;
                        div_dvd    = MS_PER_MINUTE;
                        div_dvs    = div_quo;
                        state_next = ST_RATE;
                    end
                end
            end
            ST_RATE:
            begin
                if (div_done)
                    state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    // tracker state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            for (int i = 0; i < WINDOW_LEN; i++)
                ring_reg[i] <= START_INTERVAL;
            slot_reg  <= '0;
            total_reg <= TOTAL_RESET;
            bpm_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            cal_reg   <= 1'b0;
            acc_reg   <= 1'b0;
            minc_reg  <= 1'b0;
            maxc_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        prev_reg <= edge_time_ms;
                        acc_reg  <= 1'b0;
                        minc_reg <= 1'b0;
                        maxc_reg <= 1'b0;
                    end
                end
                ST_CHECK:
                begin
                    if (in_band)
                    begin
                        acc_reg            <= 1'b1;
                        total_reg          <= total_next;
                        ring_reg[slot_reg] <= interval[RING_W-1:0];
                        if (slot_reg == SLOT_W'(WINDOW_LEN - 1))
                            slot_reg <= '0;
                        else
                            slot_reg <= slot_reg + 1'b1;
                    end
                end
                ST_AVG:
                begin
                    // zero average gives zero rate
                    if (div_done && (div_quo == '0))
                        bpm_reg <= '0;
                end
                ST_RATE:
                begin
                    if (div_done)
                        bpm_reg <= div_quo;
                end
                ST_RANGE:
                begin
                    // first positive rate calibrates both the minimum and the maximum
                    if (bpm_reg != '0)
                    begin
                        if (!cal_reg)
                        begin
                            min_reg  <= bpm_reg;
                            max_reg  <= bpm_reg;
                            cal_reg  <= 1'b1;
                            minc_reg <= 1'b1;
                            maxc_reg <= 1'b1;
                        end
                        else
                        begin
                            if (bpm_reg > max_reg)
                            begin
                                max_reg  <= bpm_reg;
                                maxc_reg <= 1'b1;
                            end
                            if (bpm_reg < min_reg)
                            begin
                                min_reg  <= bpm_reg;
                                minc_reg <= 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == ST_DONE) && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            o_acc_reg  <= acc_reg;
            o_int_reg  <= int_sat;
            o_bpm_reg  <= bpm_reg;
            o_min_reg  <= min_reg;
            o_max_reg  <= max_reg;
            o_minc_reg <= minc_reg;
            o_maxc_reg <= maxc_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = o_acc_reg;
    assign interval_ms = o_int_reg;
    assign bpm         = o_bpm_reg;
    assign bpm_min     = o_min_reg;
    assign bpm_max     = o_max_reg;
    assign min_changed = o_minc_reg;
    assign max_changed = o_maxc_reg;

endmodule

@@ sv/bbt_sub_serial.sv @@
// ----------------------------------------------------------------------------
// bbt_sub_serial: digit-serial 32-bit subtractor
// Computes minuend - subtrahend modulo 2^32, one digit per cycle, LSB first.
// ----------------------------------------------------------------------------
module bbt_sub_serial
    import bbt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [TS_W-1:0] minuend,
    input  logic [TS_W-1:0] subtrahend,
    output logic            done,
    output logic [TS_W-1:0] diff
);

    logic [TS_W-1:0]      a_reg;
    logic [TS_W-1:0]      b_reg;
    logic [TS_W-1:0]      d_reg;
    logic                 borrow_reg;
    logic [SUB_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DIGIT_W:0]     digit_sum;

    // one digit of a - b with borrow, as a + ~b + carry
    assign digit_sum = {1'b0, a_reg[DIGIT_W-1:0]} + {1'b0, ~b_reg[DIGIT_W-1:0]}
                     + (DIGIT_W+1)'(!borrow_reg);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SUB_CNT_W'(SUB_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and result shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg      <= minuend;
            b_reg      <= subtrahend;
            borrow_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            a_reg      <= a_reg >> DIGIT_W;
            b_reg      <= b_reg >> DIGIT_W;
            d_reg      <= {digit_sum[DIGIT_W-1:0], d_reg[TS_W-1:DIGIT_W]};
            borrow_reg <= !digit_sum[DIGIT_W];
        end
    end

    assign done = done_reg;
    assign diff = d_reg;

endmodule

@@ sv/bbt_div_serial.sv @@
// ----------------------------------------------------------------------------
// bbt_div_serial: bit-serial restoring divider
// 16-bit unsigned quotient, one bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
module bbt_div_serial
    import bbt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     q_reg;
    logic [DIV_W-1:0]     r_reg;
    logic [DIV_W-1:0]     d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       trial;

    // shift in the next dividend bit and try the subtract
    assign shifted = {r_reg, q_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, d_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder / quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (!trial[DIV_W])
            begin
                r_reg <= trial[DIV_W-1:0];
                q_reg <= {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted[DIV_W-1:0];
                q_reg <= {q_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for beat_interval_bpm_tracker
// Sends pulse-edge timestamps, predicts every result item with a cycle-free
// model of the interval ring and the rolling BPM, and compares each field.
// Directed edges hit the limits, saturation, wrap and the full-rate corner;
// random phases then vary both limits, the input gaps and the result stalls.
// ----------------------------------------------------------------------------
module tb_top
    import bbt_pkg::*;
();

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 65;

    // one result item, packed in port order
    typedef struct packed {
        logic             accepted;
        logic [VAL_W-1:0] interval_ms;
        logic [VAL_W-1:0] bpm;
        logic [VAL_W-1:0] bpm_min;
        logic [VAL_W-1:0] bpm_max;
        logic             min_changed;
        logic             max_changed;
    } beat_result_t;

    // ------------------------------------------------------------------------
    // Rolling BPM predictor and result checker
    // ------------------------------------------------------------------------
    class bpm_scoreboard;
        logic [LIM_W-1:0]  lim_low;
        logic [LIM_W-1:0]  lim_high;
        logic [TS_W-1:0]   last_edge;
        logic [RING_W-1:0] ring [WINDOW_LEN_DEF];
        int unsigned       slot;
        logic [VAL_W-1:0]  total;
        logic [VAL_W-1:0]  rate;
        logic [VAL_W-1:0]  rate_low;
        logic [VAL_W-1:0]  rate_high;
        bit                calibrated;
        beat_result_t      pending_results [$];
        int unsigned       errors;
        int unsigned       edges;
        int unsigned       beats;
        int unsigned       min_moves;
        int unsigned       max_moves;

        function new();
            lim_low    = LOW_RESET;
            lim_high   = HIGH_RESET;
            last_edge  = '0;
            foreach (ring[i]) ring[i] = START_INTERVAL;
            slot       = 0;
            total      = VAL_W'(WINDOW_LEN_DEF * START_INTERVAL);
            rate       = '0;
            rate_low   = '0;
            rate_high  = '0;
            calibrated = 1'b0;
            errors     = 0;
            edges      = 0;
            beats      = 0;
            min_moves  = 0;
            max_moves  = 0;
        endfunction

        function void set_limit(logic idx, logic [LIM_W-1:0] value);
            if (idx == REG_LOW)
                lim_low = value;
            else
                lim_high = value;
        endfunction

        // work out the result of one accepted edge and queue it
        function void note_edge(logic [TS_W-1:0] now);
            logic [TS_W-1:0] gap_ms;
            int unsigned     avg;
            beat_result_t    r;
            gap_ms    = now - last_edge;
            last_edge = now;
            r         = '0;
            edges++;
            if (gap_ms > lim_low && gap_ms < lim_high)
            begin
                r.accepted = 1'b1;
                beats++;
                total      = total - VAL_W'(ring[slot]) + gap_ms[VAL_W-1:0];
                ring[slot] = gap_ms[RING_W-1:0];
                slot       = (slot + 1 >= WINDOW_LEN_DEF) ? 0 : slot + 1;
                avg        = 32'(total) / WINDOW_LEN_DEF;
                rate       = (avg > 0) ? VAL_W'(32'(MS_PER_MINUTE) / avg) : '0;
                // first nonzero rate seeds both extremes
                if (rate != 0)
                begin
                    if (!calibrated)
                    begin
                        rate_low      = rate;
                        rate_high     = rate;
                        calibrated    = 1'b1;
                        r.min_changed = 1'b1;
                        r.max_changed = 1'b1;
                    end
                    else
                    begin
                        if (rate > rate_high)
                        begin
                            rate_high     = rate;
                            r.max_changed = 1'b1;
                        end
                        if (rate < rate_low)
                        begin
                            rate_low      = rate;
                            r.min_changed = 1'b1;
                        end
                    end
                end
            end
            if (r.min_changed) min_moves++;
            if (r.max_changed) max_moves++;
            r.interval_ms = (gap_ms > 32'hFFFF) ? 16'hFFFF : gap_ms[VAL_W-1:0];
            r.bpm         = rate;
            r.bpm_min     = rate_low;
            r.bpm_max     = rate_high;
            pending_results.push_back(r);
        endfunction

        function void compare(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t ns: ERROR %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(beat_result_t got);
            beat_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: ERROR unexpected result item, expected none, actual %h",
                         $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                compare("accepted", VAL_W'(want.accepted), VAL_W'(got.accepted));
                compare("interval_ms", want.interval_ms, got.interval_ms);
                compare("bpm", want.bpm, got.bpm);
                compare("bpm_min", want.bpm_min, got.bpm_min);
                compare("bpm_max", want.bpm_max, got.bpm_max);
                compare("min_changed", VAL_W'(want.min_changed), VAL_W'(got.min_changed));
                compare("max_changed", VAL_W'(want.max_changed), VAL_W'(got.max_changed));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [TS_W-1:0]   edge_time_ms = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic              accepted;
    logic [VAL_W-1:0]  interval_ms;
    logic [VAL_W-1:0]  bpm;
    logic [VAL_W-1:0]  bpm_min;
    logic [VAL_W-1:0]  bpm_max;
    logic              min_changed;
    logic              max_changed;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [APB_AW-1:0] paddr        = '0;
    logic [APB_DW-1:0] pwdata       = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bpm_scoreboard   sb;
    logic [TS_W-1:0] edge_clock = '0;   // timestamp of the last item sent
    bit              burst_mode = 1'b0; // no idling on either side
    int unsigned     cycle_count = 0;

    beat_interval_bpm_tracker uut (.*);

    // clock
    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // offer one edge item; valid stays high on return so a following item
    // can go out back to back
    task automatic send_edge(input logic [TS_W-1:0] stamp);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        edge_time_ms <= stamp;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        sb.note_edge(stamp);
        edge_clock = stamp;
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_limit(input logic idx, input logic [LIM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_limit(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_band(input logic [LIM_W-1:0] lo, input logic [LIM_W-1:0] hi);
        write_limit(REG_LOW, lo);
        write_limit(REG_HIGH, hi);
    endtask

    // result side: random stall before each result, then take it
    initial
    begin : result_side
        int unsigned  hold;
        beat_result_t got;
        forever
        begin
            hold = burst_mode ? 0 : $urandom_range(0, 9);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            got = {accepted, interval_ms, bpm, bpm_min, bpm_max, min_changed, max_changed};
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned lo;
        int unsigned hi;
        int unsigned k;
        int unsigned d;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: first edge against time 0, limit edges, saturation
        send_edge(32'd900);
        send_edge(edge_clock + 300);
        send_edge(edge_clock + 301);
        send_edge(edge_clock + 1999);
        send_edge(edge_clock + 2000);
        send_edge(edge_clock);
        send_edge(edge_clock + 65535);
        send_edge(edge_clock + 65536);
        send_edge(edge_clock + 400);
        send_edge(edge_clock + 400);
        send_edge(edge_clock + 1900);
        send_edge(edge_clock + 1900);
        // timestamp wrap and all-ones stamp
        send_edge(32'hFFFF_FFF0);
        send_edge(32'h0000_01F0);
        send_edge(32'hFFFF_FFFF);
        settle();

        // 1 ms beats drive the rate to its ceiling
        set_band(12'd0, 12'd2);
        send_edge(edge_clock + 2);
        repeat (10) send_edge(edge_clock + 1);
        settle();

        // widest band, longest beat that can pass
        set_band(12'd0, 12'd4095);
        send_edge(edge_clock + 4094);
        send_edge(edge_clock + 4095);
        settle();

        // empty band: all ones in both limits
        set_band(12'd4095, 12'd4095);
        send_edge(edge_clock + 4094);
        send_edge(edge_clock + 1000);
        settle();

        // random phases with fresh limits each time
        for (int p = 0; p < PHASES; p++)
        begin
            k = $urandom_range(0, 9);
            if (p == 0)
            begin
                lo = LOW_RESET;
                hi = HIGH_RESET;
            end
            else if (k == 0)
            begin
                lo = $urandom_range(0, 4095);
                hi = $urandom_range(1, 4095);
            end
            else if (k == 1)
            begin
                lo = 0;
                hi = 4095;
            end
            else
            begin
                lo = $urandom_range(0, 1200);
                hi = $urandom_range(lo + 2, 4095);
            end
            set_band(LIM_W'(lo), LIM_W'(hi));
            burst_mode = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                k = $urandom_range(0, 99);
                if (k < 70 && hi > lo + 1)
                begin
                    send_edge(edge_clock + $urandom_range(lo + 1, hi - 1));
                end
                else if (k < 80)
                begin
                    // band edges on both sides
                    case ($urandom_range(0, 3))
                        0: d = lo;
                        1: d = lo + 1;
                        2: d = (hi > 0) ? hi - 1 : 0;
                        default: d = hi;
                    endcase
                    send_edge(edge_clock + d);
                end
                else if (k < 90)
                begin
                    send_edge(edge_clock + $urandom_range(0, 5000));
                end
                else
                begin
                    send_edge($urandom());
                end
            end
            settle();
        end

        // let any stray result show up
        burst_mode = 1'b0;
        repeat (100) @(posedge clk);

        $display("Covered %0d edge items: %0d beats entered the ring, %0d rejected,",
                 sb.edges, sb.beats, sb.edges - sb.beats);
        $display("%0d minimum moves, %0d maximum moves, final band %0d..%0d ms.",
                 sb.min_moves, sb.max_moves, sb.lim_low, sb.lim_high);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
sv/bbt_pkg.sv
sv/bbt_sub_serial.sv
sv/bbt_div_serial.sv
sv/beat_interval_bpm_tracker.sv
verif/tb_top.sv
